// File: sv/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion, active at every edge.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

// File: sv/sqga_pkg.sv
// Package: register map, gate constants and types of the single-qubit gate core.
`timescale 1ns / 1ps

package sqga_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 14;
    localparam int NUM_GATES  = 4;
    localparam int NUM_PROD   = 16;
    localparam int TQ_W       = 4;

    localparam logic [CFG_DATA_W-1:0] GATE_ONE    = 32'h4000_0000;
    localparam logic [CFG_DATA_W-1:0] GATE_ZERO   = 32'h0000_0000;
    localparam logic [TQ_W-1:0]       TARGET_RST  = 4'd0;
    localparam logic [TQ_W-1:0]       QUBITS_RST  = 4'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_G00    = 3'd0,
        CFG_G01    = 3'd1,
        CFG_G10    = 3'd2,
        CFG_G11    = 3'd3,
        CFG_TARGET = 3'd4,
        CFG_QUBITS = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        GATE_TL = 2'd0,
        GATE_TR = 2'd1,
        GATE_BL = 2'd2,
        GATE_BR = 2'd3
    } t_gate_sel;

endpackage

// File: sv/single_qubit_gate_apply_core.sv
// Top level: streamed 2x2 complex gate on one qubit of a state vector.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_amp_real, i_amp_imag
//  out     | output    | o_out_valid / i_out_ready  | o_out_index, o_out_real, o_out_imag,
//          |           |                            | o_pair_last, o_vector_last
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item accepted per cycle unless stalled. Path: input -> stage 1 (registered partner read from the
// amplitude RAM) -> stage 2 (16 registered multiplies) -> output register (sum, round, sat).
// o_out_valid rises once the item has passed the stage 1, stage 2 and output registers.
// A paired item holds the output until both results are taken, so back-to-back pairs stall the input.
// Unless target >= qubits, items with the tested bit clear are written to the RAM and give no result.
// Reset clears control, position and config; the amplitude RAM is not cleared.
// Back-pressure on out ripples back through empty-aware stage readies to o_in_ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module single_qubit_gate_apply_core import sqga_pkg::*; #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [AMP_WIDTH-1:0]   i_amp_real,
    input  logic signed [AMP_WIDTH-1:0]   i_amp_imag,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [MAX_QUBITS-1:0]         o_out_index,
    output logic signed [AMP_WIDTH-1:0]   o_out_real,
    output logic signed [AMP_WIDTH-1:0]   o_out_imag,
    output logic                          o_pair_last,
    output logic                          o_vector_last,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int IW        = MAX_QUBITS;
    localparam int QW        = ($clog2(MAX_QUBITS + 1) > TQ_W) ? $clog2(MAX_QUBITS + 1) : TQ_W;
    localparam int MEM_DEPTH = 1 << MAX_QUBITS;
    localparam int AW        = AMP_WIDTH;
    localparam int PW        = COEF_W + AW;
    localparam int SW        = PW + 2;
    localparam int ROUND_ADD = 1 << (COEF_FRAC - 1);

    // config
    logic [CFG_DATA_W-1:0]   r_gate [NUM_GATES];
    logic [TQ_W-1:0]         r_target;
    logic [TQ_W-1:0]         r_qubits;
    logic                    cfg_acc;

    // input side
    logic [IW-1:0]           r_pos;
    logic [QW-1:0]           qe;
    logic [QW-1:0]           tq;
    logic [QW-1:0]           sh;
    logic [IW-1:0]           len_mask;
    logic [IW-1:0]           pos;
    logic [IW-1:0]           stride;
    logic [IW-1:0]           lo_idx;
    logic                    in_pass;
    logic                    in_store;
    logic                    in_last;
    logic                    in_acc;

    logic [2*AW-1:0]         r_mem [MEM_DEPTH];
    logic [2*AW-1:0]         r_rd;

    // stage 1
    logic                    r_s1_v;
    logic                    r_s1_pass;
    logic                    r_s1_last;
    logic signed [AW-1:0]    r_s1_ar;
    logic signed [AW-1:0]    r_s1_ai;
    logic [IW-1:0]           r_s1_hi_idx;
    logic [IW-1:0]           r_s1_lo_idx;

    // stage 2
    logic                    r_s2_v;
    logic                    r_s2_pass;
    logic                    r_s2_last;
    logic signed [AW-1:0]    r_s2_ar;
    logic signed [AW-1:0]    r_s2_ai;
    logic [IW-1:0]           r_s2_hi_idx;
    logic [IW-1:0]           r_s2_lo_idx;
    logic signed [PW-1:0]    r_s2_prod [NUM_PROD];
    logic signed [PW-1:0]    n_s2_prod [NUM_PROD];

    logic signed [COEF_W-1:0] g_re [NUM_GATES];
    logic signed [COEF_W-1:0] g_im [NUM_GATES];
    logic signed [AW-1:0]     x_re [NUM_GATES];
    logic signed [AW-1:0]     x_im [NUM_GATES];

    logic signed [SW-1:0]    lo_re_sum;
    logic signed [SW-1:0]    lo_im_sum;
    logic signed [SW-1:0]    hi_re_sum;
    logic signed [SW-1:0]    hi_im_sum;

    // output stage
    logic                    r_ov;
    logic                    r_hp;
    logic [IW-1:0]           r_o_idx;
    logic signed [AW-1:0]    r_o_re;
    logic signed [AW-1:0]    r_o_im;
    logic                    r_o_pl;
    logic                    r_o_vl;
    logic [IW-1:0]           r_h_idx;
    logic signed [AW-1:0]    r_h_re;
    logic signed [AW-1:0]    r_h_im;
    logic                    r_h_vl;

    logic                    out_acc;
    logic                    out_free;
    logic                    s2_ready;
    logic                    s1_ready;

    function automatic logic signed [AW-1:0] f_round_sat(input logic signed [SW-1:0] acc);
        logic signed [SW-1:0] r;
        logic signed [AW-1:0] res;
        r = (acc + SW'(ROUND_ADD)) >>> COEF_FRAC;
        if ((&r[SW-1:AW-1]) || !(|r[SW-1:AW-1])) begin
            res = r[AW-1:0];
        end else if (r[SW-1]) begin
            res = {1'b1, {(AW-1){1'b0}}};
        end else begin
            res = {1'b0, {(AW-1){1'b1}}};
        end
        return res;
    endfunction

    // ---------------- config port ----------------
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate[GATE_TL] <= GATE_ONE;
            r_gate[GATE_TR] <= GATE_ZERO;
            r_gate[GATE_BL] <= GATE_ZERO;
            r_gate[GATE_BR] <= GATE_ONE;
            r_target        <= TARGET_RST;
            r_qubits        <= QUBITS_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_G00:    r_gate[GATE_TL] <= i_cfg_data;
                CFG_G01:    r_gate[GATE_TR] <= i_cfg_data;
                CFG_G10:    r_gate[GATE_BL] <= i_cfg_data;
                CFG_G11:    r_gate[GATE_BR] <= i_cfg_data;
                CFG_TARGET: r_target        <= i_cfg_data[TQ_W-1:0];
                CFG_QUBITS: r_qubits        <= i_cfg_data[TQ_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input decode ----------------
    always_comb begin
        if (r_qubits == '0) begin
            qe = QW'(1);
        end else if (QW'(r_qubits) > QW'(MAX_QUBITS)) begin
            qe = QW'(MAX_QUBITS);
        end else begin
            qe = QW'(r_qubits);
        end
        tq       = QW'(r_target);
        sh       = qe - tq - QW'(1);
        len_mask = ~({IW{1'b1}} << qe);
        pos      = r_pos & len_mask;
        stride   = IW'(1) << sh;
        lo_idx   = pos - stride;
        in_last  = (pos == len_mask);
        in_pass  = (tq >= qe);
        in_store = !in_pass && !(|(pos & stride));
    end

    assign out_acc    = r_ov && i_out_ready;
    assign out_free   = !r_ov || (i_out_ready && !r_hp);
    assign s2_ready   = !r_s2_v || out_free;
    assign s1_ready   = !r_s1_v || s2_ready;
    assign o_in_ready = s1_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // amplitude RAM: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && in_store) begin
            r_mem[pos] <= {i_amp_real, i_amp_imag};
        end
        if (in_acc) begin
            r_rd <= r_mem[lo_idx];
        end
    end

    // ---------------- multiplies ----------------
    always_comb begin
        for (int k = 0; k < NUM_GATES; k++) begin
            g_re[k] = signed'(r_gate[k][CFG_DATA_W-1:COEF_W]);
            g_im[k] = signed'(r_gate[k][COEF_W-1:0]);
        end
        x_re[GATE_TL] = signed'(r_rd[2*AW-1:AW]);
        x_im[GATE_TL] = signed'(r_rd[AW-1:0]);
        x_re[GATE_BL] = signed'(r_rd[2*AW-1:AW]);
        x_im[GATE_BL] = signed'(r_rd[AW-1:0]);
        x_re[GATE_TR] = r_s1_ar;
        x_im[GATE_TR] = r_s1_ai;
        x_re[GATE_BR] = r_s1_ar;
        x_im[GATE_BR] = r_s1_ai;
        for (int k = 0; k < NUM_GATES; k++) begin
            n_s2_prod[4*k]     = PW'(g_re[k] * x_re[k]);
            n_s2_prod[4*k + 1] = PW'(g_im[k] * x_im[k]);
            n_s2_prod[4*k + 2] = PW'(g_re[k] * x_im[k]);
            n_s2_prod[4*k + 3] = PW'(g_im[k] * x_re[k]);
        end
    end

    // ---------------- sums ----------------
    always_comb begin
        lo_re_sum = SW'(r_s2_prod[0]) - SW'(r_s2_prod[1])
                  + SW'(r_s2_prod[4]) - SW'(r_s2_prod[5]);
        lo_im_sum = SW'(r_s2_prod[2]) + SW'(r_s2_prod[3])
                  + SW'(r_s2_prod[6]) + SW'(r_s2_prod[7]);
        hi_re_sum = SW'(r_s2_prod[8]) - SW'(r_s2_prod[9])
                  + SW'(r_s2_prod[12]) - SW'(r_s2_prod[13]);
        hi_im_sum = SW'(r_s2_prod[10]) + SW'(r_s2_prod[11])
                  + SW'(r_s2_prod[14]) + SW'(r_s2_prod[15]);
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_ov   <= 1'b0;
            r_hp   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pos <= (pos + IW'(1)) & len_mask;
            end
            if (s1_ready) begin
                r_s1_v <= in_acc && !in_store;
            end
            if (s2_ready) begin
                r_s2_v <= r_s1_v;
            end
            // output busy and accepted means the upper result of a pair moves up
            if (out_free) begin
                r_ov <= r_s2_v;
                r_hp <= r_s2_v && !r_s2_pass;
            end else if (out_acc) begin
                r_hp <= 1'b0;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_pass   <= in_pass;
            r_s1_last   <= in_last;
            r_s1_ar     <= i_amp_real;
            r_s1_ai     <= i_amp_imag;
            r_s1_hi_idx <= pos;
            r_s1_lo_idx <= lo_idx;
        end
        if (s2_ready) begin
            r_s2_pass   <= r_s1_pass;
            r_s2_last   <= r_s1_last;
            r_s2_ar     <= r_s1_ar;
            r_s2_ai     <= r_s1_ai;
            r_s2_hi_idx <= r_s1_hi_idx;
            r_s2_lo_idx <= r_s1_lo_idx;
            r_s2_prod   <= n_s2_prod;
        end
        if (out_free && r_s2_v) begin
            if (r_s2_pass) begin
                r_o_idx <= r_s2_hi_idx;
                r_o_re  <= r_s2_ar;
                r_o_im  <= r_s2_ai;
                r_o_pl  <= 1'b0;
                r_o_vl  <= r_s2_last;
            end else begin
                r_o_idx <= r_s2_lo_idx;
                r_o_re  <= f_round_sat(lo_re_sum);
                r_o_im  <= f_round_sat(lo_im_sum);
                r_o_pl  <= 1'b0;
                r_o_vl  <= 1'b0;
            end
            r_h_idx <= r_s2_hi_idx;
            r_h_re  <= f_round_sat(hi_re_sum);
            r_h_im  <= f_round_sat(hi_im_sum);
            r_h_vl  <= r_s2_last;
        end else if (out_acc && r_hp) begin
            r_o_idx <= r_h_idx;
            r_o_re  <= r_h_re;
            r_o_im  <= r_h_im;
            r_o_pl  <= 1'b1;
            r_o_vl  <= r_h_vl;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_index   = r_o_idx;
    assign o_out_real    = r_o_re;
    assign o_out_imag    = r_o_im;
    assign o_pair_last   = r_o_pl;
    assign o_vector_last = r_o_vl;

    // ---------------- assertions ----------------
    `ASSERT_CLK_RST(a_hp_needs_valid, i_clk, i_rst_n, r_hp |-> r_ov, "held result without valid")
    `ASSERT_CLK_RST(a_lo_flags, i_clk, i_rst_n, r_hp |-> !(r_o_pl || r_o_vl), "pair flags")
    `ASSERT_CLK_RST(a_hi_next, i_clk, i_rst_n, out_acc && r_hp |=> r_ov && r_o_pl, "upper lost")
    `ASSERT_CLK(a_rst_clears, i_clk, !i_rst_n |=> !(r_ov || r_s1_v || r_s2_v), "not idle")

endmodule
